[hw/rtl/rcb_pkg.sv]
`default_nettype none
package rcb_pkg;

	localparam int unsigned COMB_COUNT     = 16;
	localparam int unsigned COMB_MAX       = 16;
	localparam int unsigned COMB_TOTAL     = 17729;
	localparam int unsigned PREDELAY_DEPTH = 16384;

	localparam int unsigned CIDX_W  = (COMB_COUNT > 1) ? $clog2(COMB_COUNT) : 1;
	localparam int unsigned CADDR_W = $clog2(COMB_TOTAL);
	localparam int unsigned CPTR_W  = 11;
	localparam int unsigned PD_AW   = (PREDELAY_DEPTH > 1) ? $clog2(PREDELAY_DEPTH) : 1;
	localparam int unsigned CFG_AW  = 6;

	localparam logic signed [31:0] SEND_LIMIT = 32'sd500000;

	localparam logic [11:0] COMB_BASE [COMB_MAX] = '{
		12'd1163, 12'd1319, 12'd1471, 12'd1657, 12'd1861, 12'd2069, 12'd1531, 12'd1913,
		12'd2339, 12'd2417, 12'd2521, 12'd2683, 12'd2803, 12'd3067, 12'd3253, 12'd3407
	};

	// start of each comb line in the packed comb memory
	localparam logic [CADDR_W-1:0] COMB_OFFSET [COMB_MAX] = '{
		CADDR_W'(0),     CADDR_W'(581),   CADDR_W'(1240),  CADDR_W'(1975),
		CADDR_W'(2803),  CADDR_W'(3733),  CADDR_W'(4767),  CADDR_W'(5532),
		CADDR_W'(6488),  CADDR_W'(7657),  CADDR_W'(8865),  CADDR_W'(10125),
		CADDR_W'(11466), CADDR_W'(12867), CADDR_W'(14400), CADDR_W'(16026)
	};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FRONT,
		ST_COMB,
		ST_HOLD
	} rcb_state_t;

	typedef enum logic [2:0] {
		REG_FB_LOW   = 3'd0,
		REG_FB_HIGH  = 3'd1,
		REG_COMB_GAIN = 3'd2,
		REG_COMB_DAMP = 3'd3,
		REG_SEND_LP  = 3'd4,
		REG_SEND_HP  = 3'd5,
		REG_DRY_GAIN = 3'd6,
		REG_PREDELAY = 3'd7
	} rcb_reg_t;

	typedef struct packed {
		logic [63:0] fb_low;
		logic [63:0] fb_high;
		logic [7:0]  comb_gain;
		logic [8:0]  comb_damping;
		logic [8:0]  lp_coef;
		logic [8:0]  hp_coef;
		logic [10:0] dry_gain;
		logic [14:0] predelay_length;
	} rcb_cfg_t;

	function automatic logic [CPTR_W-1:0] comb_size(input logic [CIDX_W-1:0] idx);
		return CPTR_W'(COMB_BASE[idx] >> 1);
	endfunction

	function automatic logic comb_subtracts(input logic [CIDX_W-1:0] idx);
		return (32'(idx) & 32'd3) == 32'd3;
	endfunction

endpackage
`default_nettype wire

[hw/rtl/rcb_ifs.sv]
`default_nettype none
interface rcb_frame_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] reverb_send;
	logic signed [31:0] dry_left;
	logic signed [31:0] dry_right;

	modport source (output valid, output reverb_send, output dry_left, output dry_right,
		input ready);
	modport sink (input valid, input reverb_send, input dry_left, input dry_right,
		output ready);
endinterface

interface rcb_mix_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] out_left;
	logic signed [31:0] out_right;

	modport source (output valid, output out_left, output out_right, input ready);
	modport sink (input valid, input out_left, input out_right, output ready);
endinterface
`default_nettype wire

[hw/rtl/rcb_ram.sv]
`default_nettype none
module rcb_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

endmodule
`default_nettype wire

[hw/rtl/rcb_cfg.sv]
`default_nettype none
module rcb_cfg (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [rcb_pkg::CFG_AW-1:0] paddr,
	input  logic [63:0]               pwdata,
	output logic [63:0]               prdata,
	output logic                      pready,
	output rcb_pkg::rcb_cfg_t         cfg,
	output logic                      pd_clear
);
	import rcb_pkg::*;

	rcb_cfg_t cfg_q;
	rcb_reg_t idx;
	logic     wr_en;

	assign idx      = rcb_reg_t'(paddr[5:3]);
	assign pready   = 1'b1;
	assign wr_en    = psel && penable && pwrite;
	assign pd_clear = wr_en && (idx == REG_PREDELAY);
	assign cfg      = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fb_low          <= '0;
			cfg_q.fb_high         <= '0;
			cfg_q.comb_gain       <= 8'd64;
			cfg_q.comb_damping    <= 9'd230;
			cfg_q.lp_coef         <= 9'd76;
			cfg_q.hp_coef         <= 9'd76;
			cfg_q.dry_gain        <= 11'd256;
			cfg_q.predelay_length <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_FB_LOW:    cfg_q.fb_low       <= pwdata;
				REG_FB_HIGH:   cfg_q.fb_high      <= pwdata;
				REG_COMB_GAIN: cfg_q.comb_gain    <= pwdata[7:0];
				REG_COMB_DAMP: cfg_q.comb_damping <= pwdata[8:0];
				REG_SEND_LP:   cfg_q.lp_coef      <= pwdata[8:0];
				REG_SEND_HP:   cfg_q.hp_coef      <= pwdata[8:0];
				REG_DRY_GAIN:  cfg_q.dry_gain     <= pwdata[10:0];
				REG_PREDELAY: begin
					if (32'(pwdata[14:0]) > PREDELAY_DEPTH) begin
						cfg_q.predelay_length <= 15'(PREDELAY_DEPTH);
					end else begin
						cfg_q.predelay_length <= pwdata[14:0];
					end
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_FB_LOW:    prdata = cfg_q.fb_low;
			REG_FB_HIGH:   prdata = cfg_q.fb_high;
			REG_COMB_GAIN: prdata = 64'(cfg_q.comb_gain);
			REG_COMB_DAMP: prdata = 64'(cfg_q.comb_damping);
			REG_SEND_LP:   prdata = 64'(cfg_q.lp_coef);
			REG_SEND_HP:   prdata = 64'(cfg_q.hp_coef);
			REG_DRY_GAIN:  prdata = 64'(cfg_q.dry_gain);
			REG_PREDELAY:  prdata = 64'(cfg_q.predelay_length);
			default:       prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

[hw/rtl/rcb_front.sv]
`default_nettype none
module rcb_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  rcb_pkg::rcb_cfg_t  cfg,
	input  logic               pd_clear,
	input  logic signed [31:0] reverb_send,
	input  logic signed [31:0] dry_left,
	input  logic signed [31:0] dry_right,
	output logic               done,
	output logic signed [31:0] x,
	output logic signed [31:0] dry_left_scaled,
	output logic signed [31:0] dry_right_scaled
);
	import rcb_pkg::*;

	logic signed [31:0] lp_q;
	logic signed [31:0] hp_prev_q;
	logic [PD_AW-1:0]   pd_ptr_q;
	logic               pd_wrap_q;
	logic               done_q;

	logic               valid_s1, valid_s2, valid_s3;
	logic signed [31:0] send_s1;
	logic signed [41:0] hprod_s1;
	logic signed [43:0] dryl_s1, dryr_s1;
	logic signed [42:0] lprod_s2;
	logic signed [31:0] x_s3;
	logic               pd_on_s3, pd_wr_s3;
	logic signed [31:0] x_q;

	logic signed [31:0] send_clamped;
	logic signed [32:0] lp_diff;
	logic [31:0]        lp_new, hp_val, pd_rdata;
	logic               pd_on, pd_at_end;
	logic [PD_AW:0]     pd_nxt;

	always_comb begin
		if (reverb_send < -SEND_LIMIT) begin
			send_clamped = -SEND_LIMIT;
		end else if (reverb_send > SEND_LIMIT) begin
			send_clamped = SEND_LIMIT;
		end else begin
			send_clamped = reverb_send;
		end
	end

	assign lp_diff   = $signed({send_s1[31], send_s1}) - $signed({lp_q[31], lp_q});
	assign lp_new    = lp_q + lprod_s2[39:8];
	assign hp_val    = lp_new - hprod_s1[39:8];
	assign pd_on     = cfg.predelay_length != '0;
	assign pd_nxt    = {1'b0, pd_ptr_q} + 1'b1;
	assign pd_at_end = 32'(pd_nxt) >= 32'(cfg.predelay_length);

	rcb_ram #(.WIDTH(32), .DEPTH(PREDELAY_DEPTH)) u_pd_ram (
		.clk   (clk),
		.we    (valid_s2 && pd_on),
		.waddr (pd_ptr_q),
		.wdata (hp_val),
		.re    (valid_s2 && pd_on),
		.raddr (pd_ptr_q),
		.rdata (pd_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			valid_s3  <= 1'b0;
			done_q    <= 1'b0;
			lp_q      <= '0;
			hp_prev_q <= '0;
			pd_ptr_q  <= '0;
			pd_wrap_q <= 1'b0;
		end else begin
			valid_s1 <= start;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			done_q   <= valid_s3;
			if (valid_s2) begin
				lp_q      <= $signed(lp_new);
				hp_prev_q <= $signed(lp_new);
			end
			if (pd_clear) begin
				pd_ptr_q  <= '0;
				pd_wrap_q <= 1'b0;
			end else if (valid_s2 && pd_on) begin
				if (pd_at_end) begin
					pd_ptr_q  <= '0;
					pd_wrap_q <= 1'b1;
				end else begin
					pd_ptr_q <= pd_nxt[PD_AW-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			send_s1  <= send_clamped;
			hprod_s1 <= hp_prev_q * $signed({1'b0, cfg.hp_coef});
			dryl_s1  <= dry_left * $signed({1'b0, cfg.dry_gain});
			dryr_s1  <= dry_right * $signed({1'b0, cfg.dry_gain});
		end
		if (valid_s1) begin
			lprod_s2 <= lp_diff * $signed({1'b0, cfg.lp_coef});
		end
		if (valid_s2) begin
			x_s3     <= $signed(hp_val);
			pd_on_s3 <= pd_on;
			pd_wr_s3 <= pd_wrap_q;
		end
		if (valid_s3) begin
			if (!pd_on_s3) begin
				x_q <= x_s3;
			end else if (pd_wr_s3) begin
				x_q <= $signed(pd_rdata);
			end else begin
				x_q <= '0;
			end
		end
	end

	assign done             = done_q;
	assign x                = x_q;
	assign dry_left_scaled  = dryl_s1[39:8];
	assign dry_right_scaled = dryr_s1[39:8];

endmodule
`default_nettype wire

[hw/rtl/rcb_combs.sv]
`default_nettype none
module rcb_combs (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  rcb_pkg::rcb_cfg_t  cfg,
	input  logic signed [31:0] x,
	input  logic signed [31:0] dry_left,
	input  logic signed [31:0] dry_right,
	output logic               done,
	output logic signed [31:0] sum_left,
	output logic signed [31:0] sum_right
);
	import rcb_pkg::*;

	logic                 run_q;
	logic [CIDX_W-1:0]    cnt_q;
	logic [CPTR_W-1:0]    ptr_q [COMB_COUNT];
	logic [COMB_COUNT-1:0] wrap_q;
	logic signed [31:0]   damp_q [COMB_COUNT];
	logic signed [31:0]   acc_l_q, acc_r_q;

	logic                 valid_s1, last_s1, wr_s1;
	logic [CIDX_W-1:0]    n_s1;
	logic [CADDR_W-1:0]   addr_s1;

	logic                 valid_s2, last_s2;
	logic [CIDX_W-1:0]    n_s2;
	logic [CADDR_W-1:0]   addr_s2;
	logic signed [31:0]   l_s2;
	logic signed [40:0]   gprod_s2;
	logic signed [42:0]   dprod_s2;

	logic                 valid_s3, last_s3;
	logic [CIDX_W-1:0]    n_s3;
	logic [CADDR_W-1:0]   addr_s3;
	logic signed [31:0]   l_s3;

	logic                 valid_s4, last_s4;
	logic [CADDR_W-1:0]   addr_s4;
	logic signed [40:0]   fprod_s4;

	logic [CPTR_W-1:0]    ptr_nxt;
	logic                 at_end, is_last;
	logic [CADDR_W-1:0]   rd_addr;
	logic [31:0]          rd_data;
	logic signed [31:0]   tap, l_cur;
	logic signed [32:0]   tap_diff;
	logic [31:0]          l_new, t_val, wr_data;
	logic [127:0]         fb_all;
	logic [7:0]           fb;

	assign ptr_nxt = CPTR_W'(ptr_q[cnt_q] + 1'b1);
	assign at_end  = ptr_nxt >= comb_size(cnt_q);
	assign is_last = cnt_q == CIDX_W'(COMB_COUNT - 1);
	assign rd_addr = COMB_OFFSET[cnt_q] + CADDR_W'(ptr_q[cnt_q]);

	assign tap      = wr_s1 ? $signed(rd_data) : '0;
	assign l_cur    = damp_q[n_s1];
	assign tap_diff = $signed({tap[31], tap}) - $signed({l_cur[31], l_cur});

	assign l_new = l_s2 + dprod_s2[39:8];
	assign t_val = gprod_s2[35:4];

	assign fb_all  = {cfg.fb_high, cfg.fb_low};
	assign fb      = fb_all[8*n_s3 +: 8];
	assign wr_data = x - fprod_s4[39:8];

	rcb_ram #(.WIDTH(32), .DEPTH(COMB_TOTAL)) u_comb_ram (
		.clk   (clk),
		.we    (valid_s4),
		.waddr (addr_s4),
		.wdata (wr_data),
		.re    (run_q),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q    <= 1'b0;
			cnt_q    <= '0;
			wrap_q   <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			for (int i = 0; i < COMB_COUNT; i++) begin
				ptr_q[i]  <= '0;
				damp_q[i] <= '0;
			end
		end else begin
			valid_s1 <= run_q;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				if (at_end) begin
					ptr_q[cnt_q]  <= '0;
					wrap_q[cnt_q] <= 1'b1;
				end else begin
					ptr_q[cnt_q] <= ptr_nxt;
				end
				if (is_last) begin
					run_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			if (valid_s2) begin
				damp_q[n_s2] <= $signed(l_new);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (run_q) begin
			n_s1    <= cnt_q;
			addr_s1 <= rd_addr;
			wr_s1   <= wrap_q[cnt_q];
			last_s1 <= is_last;
		end
		if (valid_s1) begin
			n_s2     <= n_s1;
			addr_s2  <= addr_s1;
			last_s2  <= last_s1;
			l_s2     <= l_cur;
			gprod_s2 <= tap * $signed({1'b0, cfg.comb_gain});
			dprod_s2 <= tap_diff * $signed({1'b0, cfg.comb_damping});
		end
		if (valid_s2) begin
			n_s3    <= n_s2;
			addr_s3 <= addr_s2;
			last_s3 <= last_s2;
			l_s3    <= $signed(l_new);
		end
		if (valid_s3) begin
			addr_s4  <= addr_s3;
			last_s4  <= last_s3;
			fprod_s4 <= l_s3 * $signed({1'b0, fb});
		end
		if (start) begin
			acc_l_q <= dry_left;
			acc_r_q <= dry_right;
		end else if (valid_s2) begin
			if (n_s2[0]) begin
				acc_r_q <= comb_subtracts(n_s2) ? acc_r_q - t_val : acc_r_q + t_val;
			end else begin
				acc_l_q <= comb_subtracts(n_s2) ? acc_l_q - t_val : acc_l_q + t_val;
			end
		end
	end

	assign done      = valid_s4 && last_s4;
	assign sum_left  = acc_l_q;
	assign sum_right = acc_r_q;

endmodule
`default_nettype wire

[hw/rtl/reverb_comb_bank_unit.sv]
// A frame runs through the front filters, then the comb bank, then the output register.
// One frame is in flight at a time; the
//   comb bank visits one comb per cycle through the single comb memory.
// The output register lets the next frame in while a result waits.
// Reset (arst_n low, asynchronous) restores register defaults and clears all
//   filter state; delay lines read as zero until written, no clearing pass.
`default_nettype none
module reverb_comb_bank_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	rcb_frame_if.sink                 frame,
	rcb_mix_if.source                 mix,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [rcb_pkg::CFG_AW-1:0] paddr,
	input  logic [63:0]               pwdata,
	output logic [63:0]               prdata,
	output logic                      pready
);
	import rcb_pkg::*;

	rcb_cfg_t           cfg;
	logic               pd_clear;
	rcb_state_t         state_q, state_d;
	logic               front_start, front_done, comb_start, comb_done, load_out, out_free;
	logic signed [31:0] x, dry_l, dry_r, sum_l, sum_r;
	logic               out_valid_q;
	logic signed [31:0] out_left_q, out_right_q;

	rcb_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.cfg      (cfg),
		.pd_clear (pd_clear)
	);

	rcb_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (front_start),
		.cfg              (cfg),
		.pd_clear         (pd_clear),
		.reverb_send      (frame.reverb_send),
		.dry_left         (frame.dry_left),
		.dry_right        (frame.dry_right),
		.done             (front_done),
		.x                (x),
		.dry_left_scaled  (dry_l),
		.dry_right_scaled (dry_r)
	);

	rcb_combs u_combs (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (comb_start),
		.cfg       (cfg),
		.x         (x),
		.dry_left  (dry_l),
		.dry_right (dry_r),
		.done      (comb_done),
		.sum_left  (sum_l),
		.sum_right (sum_r)
	);

	assign out_free = !out_valid_q || mix.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		frame.ready = 1'b0;
		front_start = 1'b0;
		comb_start  = 1'b0;
		load_out    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				frame.ready = 1'b1;
				if (frame.valid) begin
					front_start = 1'b1;
					state_d     = ST_FRONT;
				end
			end
			ST_FRONT: begin
				if (front_done) begin
					comb_start = 1'b1;
					state_d    = ST_COMB;
				end
			end
			ST_COMB: begin
				if (comb_done) begin
					if (out_free) begin
						load_out = 1'b1;
						state_d  = ST_IDLE;
					end else begin
						state_d = ST_HOLD;
					end
				end
			end
			ST_HOLD: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (mix.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_left_q  <= sum_l;
			out_right_q <= sum_r;
		end
	end

	assign mix.valid     = out_valid_q;
	assign mix.out_left  = out_left_q;
	assign mix.out_right = out_right_q;

endmodule
`default_nettype wire

[hw/rtl/rcb_checker.sv]
`default_nettype none
module rcb_checker (
	input logic clk,
	input logic arst_n,
	input logic frame_valid,
	input logic frame_ready,
	input logic mix_valid,
	input logic mix_ready,
	input logic pready
);

	// hold a pending result until it transfers
	a_mix_hold: assert property (@(posedge clk) disable iff (!arst_n)
		mix_valid && !mix_ready |=> mix_valid)
		else $error("result dropped before transfer");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid && frame_ready |=> !frame_ready)
		else $error("second frame taken while one is in flight");

	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid && frame_ready |=> !$rose(mix_valid))
		else $error("result appeared right after input transfer");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("config port stalled");

	a_reset_idle: assert property (@(posedge clk) $rose(arst_n) |-> !mix_valid)
		else $error("result valid at reset release");

endmodule

bind reverb_comb_bank_unit rcb_checker u_rcb_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.frame_valid (frame.valid),
	.frame_ready (frame.ready),
	.mix_valid   (mix.valid),
	.mix_ready   (mix.ready),
	.pready      (pready)
);
`default_nettype wire

[verif/tb.sv]
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rcb_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int          SEND_CLAMP  = 500000;

	typedef struct {
		int left;
		int right;
	} mix_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [CFG_AW-1:0] paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;

	rcb_frame_if frame_bus();
	rcb_mix_if   mix_bus();

	reverb_comb_bank_unit uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.frame   (frame_bus),
		.mix     (mix_bus),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// settings as the block should hold them
	logic [63:0] fb_low_q   = '0;
	logic [63:0] fb_high_q  = '0;
	logic [7:0]  cgain_q    = 8'd64;
	logic [8:0]  cdamp_q    = 9'd230;
	logic [8:0]  lp_coef_q  = 9'd76;
	logic [8:0]  hp_coef_q  = 9'd76;
	logic [10:0] dry_gain_q = 11'd256;
	int unsigned pd_len     = 0;

	// filter state
	int          send_lp;
	int          hp_prev;
	int          pd_line [PREDELAY_DEPTH];
	int unsigned pd_ptr;
	int          comb_line [COMB_TOTAL];
	int unsigned comb_ptr [COMB_MAX];
	int          comb_lp [COMB_MAX];

	mix_t        expected_mix [$];
	int          mismatch_count = 0;
	int unsigned cycle_count = 0;
	bit          sender_quiet = 0;
	bit          receiver_quiet = 0;

	function automatic mix_t predict_mix(int send, int dl, int dr);
		mix_t        res;
		int          acc [2];
		int          x;
		int          d;
		int          tap;
		int          lv;
		int unsigned p;
		int unsigned size;
		int unsigned base;
		logic [63:0] bank;
		longint      fbv;
		longint      t;
		base = 0;
		if (send < -SEND_CLAMP)
			send = -SEND_CLAMP;
		if (send > SEND_CLAMP)
			send = SEND_CLAMP;
		send_lp = int'(longint'(send_lp) +
			(((longint'(send) - longint'(send_lp)) * longint'(lp_coef_q)) >>> 8));
		x = int'(longint'(send_lp) - ((longint'(hp_prev) * longint'(hp_coef_q)) >>> 8));
		hp_prev = send_lp;
		if (pd_len != 0) begin
			p = pd_ptr;
			if (p >= pd_len || p >= PREDELAY_DEPTH)
				p = 0;
			d = pd_line[p];
			pd_line[p] = x;
			p++;
			if (p >= pd_len)
				p = 0;
			pd_ptr = p;
			x = d;
		end
		acc[0] = int'((longint'(dl) * longint'(dry_gain_q)) >>> 8);
		acc[1] = int'((longint'(dr) * longint'(dry_gain_q)) >>> 8);
		for (int n = 0; n < COMB_COUNT; n++) begin
			size = int'(COMB_BASE[n]) >> 1;
			p = comb_ptr[n];
			if (p >= size)
				p = 0;
			bank = (n < 8) ? fb_low_q : fb_high_q;
			fbv = longint'((bank >> (8 * (n & 7))) & 64'hFF);
			tap = comb_line[base + p];
			t = (longint'(tap) * longint'(cgain_q)) >>> 4;
			if ((n & 3) == 3)
				acc[n & 1] = int'(longint'(acc[n & 1]) - t);
			else
				acc[n & 1] = int'(longint'(acc[n & 1]) + t);
			lv = comb_lp[n];
			lv = int'(longint'(lv) +
				(((longint'(tap) - longint'(lv)) * longint'(cdamp_q)) >>> 8));
			comb_lp[n] = lv;
			comb_line[base + p] = int'(longint'(x) - ((longint'(lv) * fbv) >>> 8));
			p++;
			if (p >= size)
				p = 0;
			comb_ptr[n] = p;
			base += size;
		end
		res.left = acc[0];
		res.right = acc[1];
		return res;
	endfunction

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("status: fail");
			$finish;
		end
	end

	task automatic report_mismatch(string what, int got, int want);
		$display("%0t mismatch on %s: got %0d (0x%08h), expected %0d (0x%08h)",
			$realtime, what, got, got, want, want);
		mismatch_count++;
	endtask

	always @(posedge clk) begin
		mix_t want;
		if (arst_n && mix_bus.valid && mix_bus.ready) begin
			if (expected_mix.size() == 0) begin
				report_mismatch("unexpected transfer left", mix_bus.out_left, 0);
			end else begin
				want = expected_mix.pop_front();
				if (mix_bus.out_left !== want.left)
					report_mismatch("out_left", mix_bus.out_left, want.left);
				if (mix_bus.out_right !== want.right)
					report_mismatch("out_right", mix_bus.out_right, want.right);
			end
		end
	end

	initial begin
		int stall;
		mix_bus.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if ($urandom_range(0, 31) == 0)
				receiver_quiet = ~receiver_quiet;
			stall = receiver_quiet ? 0 : $urandom_range(0, 10);
			if (stall != 0) begin
				mix_bus.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			mix_bus.ready <= 1'b1;
			do @(posedge clk); while (!(mix_bus.valid && mix_bus.ready));
		end
	end

	task automatic wait_drained();
		frame_bus.valid <= 1'b0;
		do @(posedge clk); while (expected_mix.size() != 0);
	endtask

	task automatic send_frame(int send, int dl, int dr);
		int gap;
		if ($urandom_range(0, 23) == 0)
			sender_quiet = ~sender_quiet;
		gap = sender_quiet ? 0 : $urandom_range(0, 10);
		if (gap != 0) begin
			frame_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		frame_bus.valid       <= 1'b1;
		frame_bus.reverb_send <= send;
		frame_bus.dry_left    <= dl;
		frame_bus.dry_right   <= dr;
		do @(posedge clk); while (!frame_bus.ready);
		expected_mix.push_back(predict_mix(send, dl, dr));
	endtask

	task automatic cfg_write(rcb_reg_t r, logic [63:0] value);
		wait_drained();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {r, 3'b000};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (r)
		REG_FB_LOW:    fb_low_q = value;
		REG_FB_HIGH:   fb_high_q = value;
		REG_COMB_GAIN: cgain_q = value[7:0];
		REG_COMB_DAMP: cdamp_q = value[8:0];
		REG_SEND_LP:   lp_coef_q = value[8:0];
		REG_SEND_HP:   hp_coef_q = value[8:0];
		REG_DRY_GAIN:  dry_gain_q = value[10:0];
		REG_PREDELAY: begin
			pd_len = int'(value[14:0]);
			if (pd_len > PREDELAY_DEPTH)
				pd_len = PREDELAY_DEPTH;
			foreach (pd_line[i])
				pd_line[i] = 0;
			pd_ptr = 0;
		end
		default: ;
		endcase
	endtask

	task automatic apply_settings(logic [63:0] fbl, logic [63:0] fbh, int cg, int cd,
			int lp, int hp, int dg, int pd);
		cfg_write(REG_FB_LOW, fbl);
		cfg_write(REG_FB_HIGH, fbh);
		cfg_write(REG_COMB_GAIN, 64'(cg));
		cfg_write(REG_COMB_DAMP, 64'(cd));
		cfg_write(REG_SEND_LP, 64'(lp));
		cfg_write(REG_SEND_HP, 64'(hp));
		cfg_write(REG_DRY_GAIN, 64'(dg));
		cfg_write(REG_PREDELAY, 64'(pd));
	endtask

	function automatic int pick_send();
		case ($urandom_range(0, 4))
		0: return int'($urandom);
		1: return int'($urandom_range(0, 1000000)) - SEND_CLAMP;
		2: return ($urandom_range(0, 1) ? SEND_CLAMP : -SEND_CLAMP) +
			int'($urandom_range(0, 4)) - 2;
		3: return int'($urandom_range(0, 8191)) - 4096;
		default: return int'($urandom_range(0, 200000)) - 100000;
		endcase
	endfunction

	function automatic int pick_dry();
		if ($urandom_range(0, 3) == 0)
			return int'($urandom_range(0, 65535)) - 32768;
		return int'($urandom);
	endfunction

	function automatic int pick_coef(int top);
		if ($urandom_range(0, 3) == 0)
			return int'($urandom_range(top + 1, 2 * top - 1 + (top == 256 ? 256 : 0)));
		return int'($urandom_range(0, top));
	endfunction

	task automatic random_settings();
		int pd;
		case ($urandom_range(0, 3))
		0: pd = 0;
		1: pd = int'($urandom_range(1, 64));
		2: pd = int'($urandom_range(1, 2000));
		default: pd = int'($urandom_range(PREDELAY_DEPTH - 2, 32767));
		endcase
		apply_settings({$urandom, $urandom}, {$urandom, $urandom},
			int'($urandom_range(0, 255)), pick_coef(256), pick_coef(256), pick_coef(256),
			int'($urandom_range(0, 2047)), pd);
	endtask

	task automatic test_send_clamp();
		send_frame(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
		send_frame(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
		send_frame(-SEND_CLAMP - 1, 0, -1);
		send_frame(-SEND_CLAMP, -1, 0);
		send_frame(SEND_CLAMP, 1, 1);
		send_frame(SEND_CLAMP + 1, 32'sh5555_5555, 32'shAAAA_AAAA);
		send_frame(0, 32'shAAAA_AAAA, 32'sh5555_5555);
	endtask

	task automatic test_dry_gain();
		cfg_write(REG_DRY_GAIN, 64'd0);
		send_frame(-1, 32'sh7FFF_FFFF, 32'sh8000_0000);
		cfg_write(REG_DRY_GAIN, 64'h7FF);
		send_frame(12345, 32'sh7FFF_FFFF, 32'sh8000_0000);
		send_frame(-12345, 32'sh8000_0000, 32'sh7FFF_FFFF);
		cfg_write(REG_DRY_GAIN, 64'd1024);
		send_frame(SEND_CLAMP, 32'sh7FFF_FFFF, -7);
		send_frame(-SEND_CLAMP, -7, 32'sh8000_0000);
	endtask

	task automatic test_coef_overrange();
		apply_settings('1, '1, 255, 511, 511, 511, 256, 0);
		send_frame(SEND_CLAMP, 1000, -1000);
		send_frame(-SEND_CLAMP, 1000, -1000);
		send_frame(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
		send_frame(77777, -5, 5);
		apply_settings('0, '0, 0, 0, 0, 0, 256, 0);
		send_frame(SEND_CLAMP, 3, 4);
		send_frame(-SEND_CLAMP, -3, -4);
	endtask

	task automatic test_predelay();
		apply_settings(64'hC0C0_C0C0_C0C0_C0C0, 64'hB0B0_B0B0_B0B0_B0B0, 64, 230, 256, 76,
			256, 1);
		send_frame(SEND_CLAMP, 0, 0);
		send_frame(-200000, 0, 0);
		cfg_write(REG_PREDELAY, 64'h7FFF);
		send_frame(SEND_CLAMP, 9, 9);
		cfg_write(REG_PREDELAY, 64'd3);
		send_frame(SEND_CLAMP, 0, 0);
		send_frame(100000, 0, 0);
		cfg_write(REG_PREDELAY, 64'd3);
		send_frame(-SEND_CLAMP, 0, 0);
	endtask

	task automatic test_random();
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
			0: apply_settings(64'hC8C4_C0BC_C8C4_C0BC, 64'hBCC0_C4C8_BCC0_C4C8, 64, 230, 76,
				76, 256, int'($urandom_range(1, 40)));
			1: apply_settings('1, '1, 255, 511, 511, 511, 2047, PREDELAY_DEPTH);
			2: apply_settings('0, '0, 0, 0, 0, 0, 0, 0);
			default: random_settings();
			endcase
			for (int k = 0; k < 165; k++) begin
				if (ph == 0 && k == 80)
					wait_drained();
				send_frame(pick_send(), pick_dry(), pick_dry());
			end
		end
	endtask

	initial begin
		arst_n                = 1'b0;
		psel                 <= 1'b0;
		penable              <= 1'b0;
		pwrite               <= 1'b0;
		paddr                <= '0;
		pwdata               <= '0;
		frame_bus.valid       <= 1'b0;
		frame_bus.reverb_send <= '0;
		frame_bus.dry_left    <= '0;
		frame_bus.dry_right   <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_send_clamp();
		test_dry_gain();
		test_coef_overrange();
		test_predelay();
		test_random();
		wait_drained();
		repeat (40) @(posedge clk);
		if (mismatch_count == 0 && expected_mix.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d mismatches", mismatch_count);
			$display("status: fail");
		end
		$finish;
	end
endmodule
`default_nettype wire

[filelist.f]
hw/rtl/rcb_pkg.sv
hw/rtl/rcb_ifs.sv
hw/rtl/rcb_ram.sv
hw/rtl/rcb_cfg.sv
hw/rtl/rcb_front.sv
hw/rtl/rcb_combs.sv
hw/rtl/reverb_comb_bank_unit.sv
hw/rtl/rcb_checker.sv
verif/tb.sv
